[rtl/assert_macros.svh]
// Assertion macros for the RTL file that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, masked while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/tthr_pkg.sv]
// Shared types and constants of the tap and hold recognizer.
`default_nettype none

package tthr_pkg;

   localparam int COORD_BITS     = 16;
   localparam int STEP_BITS      = COORD_BITS + 1;
   localparam int ACC_BITS       = 32;
   localparam int TIME_BITS      = 32;
   localparam int CFG_BITS       = 16;
   localparam int CSR_INDEX_BITS = 2;
   localparam int MASK_BITS      = 3;
   localparam int MAX_RESULTS    = 3;
   localparam int SLOT_BITS      = $clog2(MAX_RESULTS);
   localparam int COUNT_BITS     = $clog2(MAX_RESULTS + 1);
   localparam int QUEUE_DEPTH    = 4;
   localparam int QPTR_BITS      = $clog2(QUEUE_DEPTH);
   localparam int QCOUNT_BITS    = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      KIND_PRESS   = 2'd0,
      KIND_MOVE    = 2'd1,
      KIND_RELEASE = 2'd2,
      KIND_TICK    = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      EV_MOVE = 2'd0,
      EV_DOWN = 2'd1,
      EV_UP   = 2'd2
   } event_type;

   typedef enum logic [1:0] {
      BTN_PRIMARY = 2'd0,
      BTN_HOLD    = 2'd1,
      BTN_CONTACT = 2'd2
   } button_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_TOUCH_MODE     = 2'd0,
      CSR_HOLD_THRESHOLD = 2'd1,
      CSR_STILL_RADIUS   = 2'd2,
      CSR_RELEASE_DELAY  = 2'd3
   } csr_index_type;

   localparam logic [MASK_BITS-1:0] MASK_PRIMARY = 3'b001;
   localparam logic [MASK_BITS-1:0] MASK_HOLD    = 3'b010;
   localparam logic [MASK_BITS-1:0] MASK_CONTACT = 3'b100;

   localparam logic                RST_TOUCH_MODE     = 1'b1;
   localparam logic [CFG_BITS-1:0] RST_HOLD_THRESHOLD = 16'd500;
   localparam logic [CFG_BITS-1:0] RST_STILL_RADIUS   = 16'd10;
   localparam logic [CFG_BITS-1:0] RST_RELEASE_DELAY  = 16'd100;

   typedef struct packed {
      logic                touch_mode;
      logic [CFG_BITS-1:0] hold_threshold_ms;
      logic [CFG_BITS-1:0] still_radius;
      logic [CFG_BITS-1:0] release_delay_ms;
   } cfg_type;

   // One result of a request, less the fields shared by all its results.
   typedef struct packed {
      event_type            event_res;
      button_type           button_id;
      logic [MASK_BITS-1:0] button_mask;
   } slot_type;

   // Everything the back end needs to emit the results of one request.
   typedef struct packed {
      slot_type [MAX_RESULTS-1:0]   slots;
      logic [COUNT_BITS-1:0]        count;
      logic                         first_old;  // first result shows the old position
      logic signed [COORD_BITS-1:0] old_x;
      logic signed [COORD_BITS-1:0] old_y;
      logic signed [COORD_BITS-1:0] new_x;
      logic signed [COORD_BITS-1:0] new_y;
      logic signed [STEP_BITS-1:0]  dx;
      logic signed [STEP_BITS-1:0]  dy;
      logic [ACC_BITS-1:0]          tot_x;
      logic [ACC_BITS-1:0]          tot_y;
   } entry_type;

   typedef struct packed {
      logic [QCOUNT_BITS-1:0] level;
      logic                   empty;
      logic                   full;
   } queue_status_type;

endpackage

`default_nettype wire

[rtl/tthr_front.sv]
// Front end: takes requests, tracks motion and gesture state, plans the results.
`default_nettype none

module tthr_front import tthr_pkg::*; (
   input  logic                         clock,
   input  logic                         reset,
   input  cfg_type                      cfg,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [1:0]                   req_kind,
   input  logic signed [COORD_BITS-1:0] req_pos_x_in,
   input  logic signed [COORD_BITS-1:0] req_pos_y_in,
   input  logic [TIME_BITS-1:0]         req_time_ms,
   input  queue_status_type             queue_status,
   output logic                         push_valid,
   output entry_type                    push_entry
);

   typedef struct packed {
      kind_type                     kind;
      logic [TIME_BITS-1:0]         now_ms;
      logic signed [STEP_BITS-1:0]  dx;
      logic signed [STEP_BITS-1:0]  dy;
      logic signed [COORD_BITS-1:0] old_x;
      logic signed [COORD_BITS-1:0] old_y;
      logic signed [COORD_BITS-1:0] new_x;
      logic signed [COORD_BITS-1:0] new_y;
      logic [ACC_BITS-1:0]          tot_x;
      logic [ACC_BITS-1:0]          tot_y;
      logic [ACC_BITS-1:0]          gest_x;
      logic [ACC_BITS-1:0]          gest_y;
   } s1_type;

   typedef struct packed {
      s1_type              base;
      logic [ACC_BITS-1:0] mag;   // larger of the two gesture magnitudes
   } s2_type;

   // motion state, updated at accept
   logic signed [COORD_BITS-1:0] cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic [ACC_BITS-1:0]          accum_x_ff, accum_x_in, accum_y_ff, accum_y_in;
   logic [ACC_BITS-1:0]          gest_x_ff, gest_x_in, gest_y_ff, gest_y_in;

   // gesture state, updated in the decision stage
   logic [MASK_BITS-1:0] held_ff, held_in;
   logic [ACC_BITS-1:0]  peak_ff, peak_in;
   logic [TIME_BITS-1:0] press_stamp_ff, press_stamp_in;
   logic [TIME_BITS-1:0] release_stamp_ff, release_stamp_in;
   logic                 press_armed_ff, press_armed_in;
   logic                 release_armed_ff, release_armed_in;

   logic   s1_valid_ff, s2_valid_ff;
   s1_type s1_ff, s1_in;
   s2_type s2_ff, s2_in;

   logic                        accept;
   kind_type                    kind_in;
   logic signed [STEP_BITS-1:0] step_x, step_y;
   logic [ACC_BITS-1:0]         step_x_ext, step_y_ext;
   logic [QCOUNT_BITS:0]        committed;

   // slots already promised: queued entries plus requests still in flight
   assign committed = {1'b0, queue_status.level}
                    + (QCOUNT_BITS+1)'(s1_valid_ff)
                    + (QCOUNT_BITS+1)'(s2_valid_ff);
   assign req_stall = committed >= (QCOUNT_BITS+1)'(QUEUE_DEPTH);
   assign accept    = req_valid && !req_stall;
   assign kind_in   = kind_type'(req_kind);

   assign step_x = {req_pos_x_in[COORD_BITS-1], req_pos_x_in}
                 - {cur_x_ff[COORD_BITS-1], cur_x_ff};
   assign step_y = {req_pos_y_in[COORD_BITS-1], req_pos_y_in}
                 - {cur_y_ff[COORD_BITS-1], cur_y_ff};
   assign step_x_ext = {{(ACC_BITS-STEP_BITS){step_x[STEP_BITS-1]}}, step_x};
   assign step_y_ext = {{(ACC_BITS-STEP_BITS){step_y[STEP_BITS-1]}}, step_y};

   // accept stage
   always_comb begin
      cur_x_in   = cur_x_ff;
      cur_y_in   = cur_y_ff;
      accum_x_in = accum_x_ff;
      accum_y_in = accum_y_ff;
      gest_x_in  = gest_x_ff;
      gest_y_in  = gest_y_ff;
      if (accept) begin
         case (kind_in)
            KIND_PRESS: begin
               accum_x_in = '0;
               accum_y_in = '0;
               if (cfg.touch_mode) begin
                  gest_x_in = '0;
                  gest_y_in = '0;
               end
               cur_x_in = req_pos_x_in;
               cur_y_in = req_pos_y_in;
            end
            KIND_MOVE, KIND_RELEASE: begin
               accum_x_in = accum_x_ff + step_x_ext;
               accum_y_in = accum_y_ff + step_y_ext;
               gest_x_in  = gest_x_ff + step_x_ext;
               gest_y_in  = gest_y_ff + step_y_ext;
               cur_x_in   = req_pos_x_in;
               cur_y_in   = req_pos_y_in;
            end
            default: ;
         endcase
      end
      s1_in.kind   = kind_in;
      s1_in.now_ms = req_time_ms;
      s1_in.dx     = (kind_in == KIND_MOVE) ? step_x : '0;
      s1_in.dy     = (kind_in == KIND_MOVE) ? step_y : '0;
      s1_in.old_x  = cur_x_ff;
      s1_in.old_y  = cur_y_ff;
      s1_in.new_x  = cur_x_in;
      s1_in.new_y  = cur_y_in;
      s1_in.tot_x  = accum_x_in;
      s1_in.tot_y  = accum_y_in;
      s1_in.gest_x = gest_x_in;
      s1_in.gest_y = gest_y_in;
   end

   // magnitude stage; the most negative sum reads as 2^31 unsigned
   logic [ACC_BITS-1:0] mag_x, mag_y;
   assign mag_x = s1_ff.gest_x[ACC_BITS-1] ? (ACC_BITS'(0) - s1_ff.gest_x) : s1_ff.gest_x;
   assign mag_y = s1_ff.gest_y[ACC_BITS-1] ? (ACC_BITS'(0) - s1_ff.gest_y) : s1_ff.gest_y;
   assign s2_in.base = s1_ff;
   assign s2_in.mag  = (mag_y > mag_x) ? mag_y : mag_x;

   // decision stage
   logic [ACC_BITS-1:0]  radius_ext;
   logic [TIME_BITS-1:0] hold_ext, delay_ext, press_age, release_age;
   logic                 tap, still;

   assign radius_ext  = {{(ACC_BITS-CFG_BITS){1'b0}}, cfg.still_radius};
   assign hold_ext    = {{(TIME_BITS-CFG_BITS){1'b0}}, cfg.hold_threshold_ms};
   assign delay_ext   = {{(TIME_BITS-CFG_BITS){1'b0}}, cfg.release_delay_ms};
   assign press_age   = s2_ff.base.now_ms - press_stamp_ff;
   assign release_age = s2_ff.base.now_ms - release_stamp_ff;
   assign still       = peak_ff < radius_ext;
   assign tap         = still && (s2_ff.mag < radius_ext);

   always_comb begin
      held_in          = held_ff;
      peak_in          = peak_ff;
      press_stamp_in   = press_stamp_ff;
      release_stamp_in = release_stamp_ff;
      press_armed_in   = press_armed_ff;
      release_armed_in = release_armed_ff;

      push_entry           = '0;
      push_entry.old_x     = s2_ff.base.old_x;
      push_entry.old_y     = s2_ff.base.old_y;
      push_entry.new_x     = s2_ff.base.new_x;
      push_entry.new_y     = s2_ff.base.new_y;
      push_entry.dx        = s2_ff.base.dx;
      push_entry.dy        = s2_ff.base.dy;
      push_entry.tot_x     = s2_ff.base.tot_x;
      push_entry.tot_y     = s2_ff.base.tot_y;

      if (s2_valid_ff) begin
         case (s2_ff.base.kind)
            KIND_PRESS: begin
               if (!cfg.touch_mode) begin
                  held_in = held_ff | MASK_PRIMARY;
                  push_entry.slots[0] = '{EV_DOWN, BTN_PRIMARY, held_in};
                  push_entry.count    = COUNT_BITS'(1);
               end else begin
                  press_stamp_in = s2_ff.base.now_ms;
                  press_armed_in = 1'b1;
                  peak_in        = '0;
                  if (release_armed_ff) begin
                     // pending tap click goes up first, at the old position
                     held_in = held_ff & ~MASK_PRIMARY;
                     release_armed_in     = 1'b0;
                     push_entry.first_old = 1'b1;
                     push_entry.slots[0]  = '{EV_UP, BTN_PRIMARY, held_in};
                     push_entry.slots[1]  = '{EV_MOVE, BTN_PRIMARY, held_in};
                     held_in = held_in | MASK_CONTACT;
                     push_entry.slots[2]  = '{EV_DOWN, BTN_CONTACT, held_in};
                     push_entry.count     = COUNT_BITS'(3);
                  end else begin
                     push_entry.slots[0] = '{EV_MOVE, BTN_PRIMARY, held_ff};
                     held_in = held_ff | MASK_CONTACT;
                     push_entry.slots[1] = '{EV_DOWN, BTN_CONTACT, held_in};
                     push_entry.count    = COUNT_BITS'(2);
                  end
               end
            end
            KIND_MOVE: begin
               peak_in = (s2_ff.mag > peak_ff) ? s2_ff.mag : peak_ff;
               push_entry.slots[0] = '{EV_MOVE, BTN_PRIMARY, held_ff};
               push_entry.count    = COUNT_BITS'(1);
            end
            KIND_RELEASE: begin
               peak_in = (s2_ff.mag > peak_ff) ? s2_ff.mag : peak_ff;
               if (!cfg.touch_mode) begin
                  held_in = held_ff & ~MASK_PRIMARY;
                  push_entry.slots[0] = '{EV_UP, BTN_PRIMARY, held_in};
                  push_entry.count    = COUNT_BITS'(1);
               end else if ((held_ff & MASK_CONTACT) != '0) begin
                  held_in = held_ff & ~MASK_CONTACT;
                  push_entry.slots[0] = '{EV_UP, BTN_CONTACT, held_in};
                  push_entry.count    = COUNT_BITS'(1);
                  if (tap) begin
                     held_in = held_in | MASK_PRIMARY;
                     push_entry.slots[1] = '{EV_DOWN, BTN_PRIMARY, held_in};
                     push_entry.count    = COUNT_BITS'(2);
                     press_armed_in      = 1'b0;
                     release_stamp_in    = s2_ff.base.now_ms;
                     release_armed_in    = 1'b1;
                  end
               end else if ((held_ff & MASK_HOLD) != '0) begin
                  held_in = held_ff & ~MASK_HOLD;
                  push_entry.slots[0] = '{EV_UP, BTN_HOLD, held_in};
                  push_entry.count    = COUNT_BITS'(1);
               end
            end
            KIND_TICK: begin
               if (cfg.touch_mode) begin
                  if (press_armed_ff && (press_age > hold_ext) && still) begin
                     held_in = held_ff & ~MASK_CONTACT;
                     push_entry.slots[0] = '{EV_UP, BTN_CONTACT, held_in};
                     held_in = held_in | MASK_HOLD;
                     push_entry.slots[1] = '{EV_DOWN, BTN_HOLD, held_in};
                     push_entry.count    = COUNT_BITS'(2);
                     press_armed_in      = 1'b0;
                  end else if (press_armed_ff && (press_age > hold_ext)) begin
                     press_armed_in = 1'b0;
                  end else if (release_armed_ff && (release_age > delay_ext)) begin
                     held_in = held_ff & ~MASK_PRIMARY;
                     push_entry.slots[0] = '{EV_UP, BTN_PRIMARY, held_in};
                     push_entry.count    = COUNT_BITS'(1);
                     release_armed_in    = 1'b0;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   assign push_valid = s2_valid_ff && (push_entry.count != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_x_ff         <= '0;
         cur_y_ff         <= '0;
         accum_x_ff       <= '0;
         accum_y_ff       <= '0;
         gest_x_ff        <= '0;
         gest_y_ff        <= '0;
         held_ff          <= '0;
         peak_ff          <= '0;
         press_stamp_ff   <= '0;
         release_stamp_ff <= '0;
         press_armed_ff   <= 1'b0;
         release_armed_ff <= 1'b0;
         s1_valid_ff      <= 1'b0;
         s2_valid_ff      <= 1'b0;
      end else begin
         cur_x_ff         <= cur_x_in;
         cur_y_ff         <= cur_y_in;
         accum_x_ff       <= accum_x_in;
         accum_y_ff       <= accum_y_in;
         gest_x_ff        <= gest_x_in;
         gest_y_ff        <= gest_y_in;
         held_ff          <= held_in;
         peak_ff          <= peak_in;
         press_stamp_ff   <= press_stamp_in;
         release_stamp_ff <= release_stamp_in;
         press_armed_ff   <= press_armed_in;
         release_armed_ff <= release_armed_in;
         s1_valid_ff      <= accept;
         s2_valid_ff      <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff <= s1_in;
      s2_ff <= s2_in;
   end

endmodule

`default_nettype wire

[rtl/tthr_queue.sv]
// Short FIFO of planned result groups between front and back end.
`default_nettype none

module tthr_queue import tthr_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  entry_type        push_entry,
   input  logic             pop,
   output entry_type        head,
   output queue_status_type status
);

   entry_type              mem_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QCOUNT_BITS-1:0] level_ff, level_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      level_in  = level_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         level_in = level_ff + 1'b1;
      end else if (pop && !push) begin
         level_in = level_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign head         = mem_ff[rd_ptr_ff];
   assign status.level = level_ff;
   assign status.empty = (level_ff == '0);
   assign status.full  = (level_ff == QCOUNT_BITS'(QUEUE_DEPTH));

endmodule

`default_nettype wire

[rtl/tthr_back.sv]
// Back end: walks the results of the head entry into the response register.
`default_nettype none

module tthr_back import tthr_pkg::*; (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         head_valid,
   input  entry_type                    head,
   output logic                         pop,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [1:0]                   rsp_event_res,
   output logic [1:0]                   rsp_button_id,
   output logic signed [STEP_BITS-1:0]  rsp_move_dx,
   output logic signed [STEP_BITS-1:0]  rsp_move_dy,
   output logic signed [COORD_BITS-1:0] rsp_pos_x,
   output logic signed [COORD_BITS-1:0] rsp_pos_y,
   output logic [MASK_BITS-1:0]         rsp_button_mask,
   output logic signed [ACC_BITS-1:0]   rsp_total_dx,
   output logic signed [ACC_BITS-1:0]   rsp_total_dy,
   output logic                         rsp_last
);

   logic [SLOT_BITS-1:0]         slot_idx_ff, slot_idx_in;
   logic                         valid_ff, valid_in;
   event_type                    event_ff;
   button_type                   button_ff;
   logic signed [STEP_BITS-1:0]  dx_ff, dy_ff;
   logic signed [COORD_BITS-1:0] pos_x_ff, pos_y_ff;
   logic [MASK_BITS-1:0]         mask_ff;
   logic [ACC_BITS-1:0]          tot_x_ff, tot_y_ff;
   logic                         last_ff;

   slot_type slot;
   logic     load, last_slot, use_old;

   assign slot      = head.slots[slot_idx_ff];
   assign last_slot = (COUNT_BITS'(slot_idx_ff) == (head.count - COUNT_BITS'(1)));
   assign use_old   = head.first_old && (slot_idx_ff == '0);
   assign load      = head_valid && (!valid_ff || !rsp_stall);
   assign pop       = load && last_slot;

   always_comb begin
      slot_idx_in = slot_idx_ff;
      valid_in    = valid_ff && rsp_stall;
      if (load) begin
         valid_in    = 1'b1;
         slot_idx_in = last_slot ? '0 : slot_idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_idx_ff <= '0;
         valid_ff    <= 1'b0;
      end else begin
         slot_idx_ff <= slot_idx_in;
         valid_ff    <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         event_ff  <= slot.event_res;
         button_ff <= slot.button_id;
         mask_ff   <= slot.button_mask;
         dx_ff     <= head.dx;
         dy_ff     <= head.dy;
         pos_x_ff  <= use_old ? head.old_x : head.new_x;
         pos_y_ff  <= use_old ? head.old_y : head.new_y;
         tot_x_ff  <= head.tot_x;
         tot_y_ff  <= head.tot_y;
         last_ff   <= last_slot;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_event_res   = event_ff;
   assign rsp_button_id   = button_ff;
   assign rsp_move_dx     = dx_ff;
   assign rsp_move_dy     = dy_ff;
   assign rsp_pos_x       = pos_x_ff;
   assign rsp_pos_y       = pos_y_ff;
   assign rsp_button_mask = mask_ff;
   assign rsp_total_dx    = tot_x_ff;
   assign rsp_total_dy    = tot_y_ff;
   assign rsp_last        = last_ff;

endmodule

`default_nettype wire

[rtl/touch_tap_hold_recognizer.sv]
// Top level of the tap and hold recognizer: CSRs, front end, queue, back end.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  kind, position, time stamp
//   rsp      out        rsp_valid/rsp_stall  event, button, steps, position, mask, totals
//   csr      in         csr_wr_en            index, 16-bit write data
//
// A request is accepted every cycle while fewer than four are queued or in flight.
// Each request yields 0 to 3 responses; the back end emits one response per cycle
// while rsp_stall is low. After acceptance a request passes the magnitude stage,
// then decide and queue write, and its responses leave through the output register.
// Synchronous reset clears state, queue and CSRs to their defaults. rsp_stall
// holds the output register; the queue absorbs the front end.
`default_nettype none

`include "assert_macros.svh"

module touch_tap_hold_recognizer import tthr_pkg::*; (
   input  logic                         clock,
   input  logic                         reset,
   // requests
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [1:0]                   req_kind,
   input  logic signed [COORD_BITS-1:0] req_pos_x_in,
   input  logic signed [COORD_BITS-1:0] req_pos_y_in,
   input  logic [TIME_BITS-1:0]         req_time_ms,
   // responses
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [1:0]                   rsp_event_res,
   output logic [1:0]                   rsp_button_id,
   output logic signed [STEP_BITS-1:0]  rsp_move_dx,
   output logic signed [STEP_BITS-1:0]  rsp_move_dy,
   output logic signed [COORD_BITS-1:0] rsp_pos_x,
   output logic signed [COORD_BITS-1:0] rsp_pos_y,
   output logic [MASK_BITS-1:0]         rsp_button_mask,
   output logic signed [ACC_BITS-1:0]   rsp_total_dx,
   output logic signed [ACC_BITS-1:0]   rsp_total_dy,
   output logic                         rsp_last,
   // configuration
   input  logic                         csr_wr_en,
   input  logic [CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [CFG_BITS-1:0]          csr_wdata
);

   cfg_type          cfg_ff, cfg_in;
   logic             push_valid, pop;
   entry_type        push_entry, head;
   queue_status_type queue_status;

   // CSR file; writes must land only while the block is idle; the block does not enforce it
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_TOUCH_MODE:     cfg_in.touch_mode        = csr_wdata[0];
            CSR_HOLD_THRESHOLD: cfg_in.hold_threshold_ms = csr_wdata;
            CSR_STILL_RADIUS:   cfg_in.still_radius      = csr_wdata;
            CSR_RELEASE_DELAY:  cfg_in.release_delay_ms  = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.touch_mode        <= RST_TOUCH_MODE;
         cfg_ff.hold_threshold_ms <= RST_HOLD_THRESHOLD;
         cfg_ff.still_radius      <= RST_STILL_RADIUS;
         cfg_ff.release_delay_ms  <= RST_RELEASE_DELAY;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front end: accept, gesture magnitude, decision; pushes one entry per request with results
   tthr_front u_front (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_kind     (req_kind),
      .req_pos_x_in (req_pos_x_in),
      .req_pos_y_in (req_pos_y_in),
      .req_time_ms  (req_time_ms),
      .queue_status (queue_status),
      .push_valid   (push_valid),
      .push_entry   (push_entry)
   );

   tthr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push_valid),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .status     (queue_status)
   );

   // back end: one response per cycle out of the head entry while rsp_stall is low
   tthr_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_valid      (!queue_status.empty),
      .head            (head),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_event_res   (rsp_event_res),
      .rsp_button_id   (rsp_button_id),
      .rsp_move_dx     (rsp_move_dx),
      .rsp_move_dy     (rsp_move_dy),
      .rsp_pos_x       (rsp_pos_x),
      .rsp_pos_y       (rsp_pos_y),
      .rsp_button_mask (rsp_button_mask),
      .rsp_total_dx    (rsp_total_dx),
      .rsp_total_dy    (rsp_total_dy),
      .rsp_last        (rsp_last)
   );

   logic push_only, contact_down, contact_held, primary_up, primary_held;

   assign push_only    = push_valid && !pop;
   assign contact_down = rsp_valid && (rsp_event_res == EV_DOWN)
                      && (rsp_button_id == BTN_CONTACT);
   assign primary_up   = rsp_valid && (rsp_event_res == EV_UP)
                      && (rsp_button_id == BTN_PRIMARY);
   assign contact_held = (rsp_button_mask & MASK_CONTACT) != '0;
   assign primary_held = (rsp_button_mask & MASK_PRIMARY) != '0;

   // the stall credit must keep the queue from overflowing
   `ASSERT_IMPLIES(a_no_overflow, clock, reset, push_only, !queue_status.full, "queue overflow")
   // a response can only come out of a queued entry
   `ASSERT_IMPLIES(a_pop_nonempty, clock, reset, pop, !queue_status.empty, "pop from empty queue")
   // contact down always shows contact held
   `ASSERT_IMPLIES(a_contact_down, clock, reset, contact_down, contact_held, "contact bit clear")
   // primary up always shows primary released
   `ASSERT_IMPLIES(a_primary_up, clock, reset, primary_up, !primary_held, "primary bit set")

endmodule

`default_nettype wire

[dv/testbench.sv]
// Self-checking testbench for the touch tap and hold recognizer.
`timescale 1ns / 1ps

module testbench;
   import tthr_pkg::*;

   // One expected response, laid out like the rsp_ ports.
   typedef struct packed {
      event_type                    event_res;
      button_type                   button_id;
      logic signed [STEP_BITS-1:0]  move_dx;
      logic signed [STEP_BITS-1:0]  move_dy;
      logic signed [COORD_BITS-1:0] pos_x;
      logic signed [COORD_BITS-1:0] pos_y;
      logic [MASK_BITS-1:0]         button_mask;
      logic [ACC_BITS-1:0]          total_dx;
      logic [ACC_BITS-1:0]          total_dy;
      logic                         last;
   } pointer_event_type;

   typedef enum {ROW_REQUEST, ROW_SETTINGS} row_op_type;

   // Directed script row: either one request or a full register setting.
   // Typed rows carry their expected response inline instead of the predictor's.
   typedef struct {
      row_op_type                   op;
      kind_type                     kind;
      logic signed [COORD_BITS-1:0] x;
      logic signed [COORD_BITS-1:0] y;
      logic [TIME_BITS-1:0]         t;
      cfg_type                      cfg;
      bit                           typed;
      int                           typed_count;
      event_type                    ev;
      button_type                   btn;
      logic [MASK_BITS-1:0]         mask;
   } script_row_type;

   localparam int DRAIN_CYCLES    = 32;   // covers requests that produce no response
   localparam int HOLD_OFF_CYCLES = 300;  // long receiver hold-off to fill the block

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_stall;
   kind_type                     req_kind = KIND_PRESS;
   logic signed [COORD_BITS-1:0] req_pos_x_in = '0;
   logic signed [COORD_BITS-1:0] req_pos_y_in = '0;
   logic [TIME_BITS-1:0]         req_time_ms = '0;
   logic                         rsp_valid;
   logic                         rsp_stall = 1'b0;
   logic [1:0]                   rsp_event_res;
   logic [1:0]                   rsp_button_id;
   logic signed [STEP_BITS-1:0]  rsp_move_dx;
   logic signed [STEP_BITS-1:0]  rsp_move_dy;
   logic signed [COORD_BITS-1:0] rsp_pos_x;
   logic signed [COORD_BITS-1:0] rsp_pos_y;
   logic [MASK_BITS-1:0]         rsp_button_mask;
   logic signed [ACC_BITS-1:0]   rsp_total_dx;
   logic signed [ACC_BITS-1:0]   rsp_total_dy;
   logic                         rsp_last;
   logic                         csr_wr_en = 1'b0;
   csr_index_type                csr_index = CSR_TOUCH_MODE;
   logic [CFG_BITS-1:0]          csr_wdata = '0;

   always #1 clock = ~clock;

   touch_tap_hold_recognizer i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_kind        (req_kind),
      .req_pos_x_in    (req_pos_x_in),
      .req_pos_y_in    (req_pos_y_in),
      .req_time_ms     (req_time_ms),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_event_res   (rsp_event_res),
      .rsp_button_id   (rsp_button_id),
      .rsp_move_dx     (rsp_move_dx),
      .rsp_move_dy     (rsp_move_dy),
      .rsp_pos_x       (rsp_pos_x),
      .rsp_pos_y       (rsp_pos_y),
      .rsp_button_mask (rsp_button_mask),
      .rsp_total_dx    (rsp_total_dx),
      .rsp_total_dy    (rsp_total_dy),
      .rsp_last        (rsp_last),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   // ---------------------------------------------------------------------------
   // Gesture predictor: own copy of the registers and the recognizer state.
   // ---------------------------------------------------------------------------
   cfg_type settings = '{RST_TOUCH_MODE, RST_HOLD_THRESHOLD, RST_STILL_RADIUS,
                         RST_RELEASE_DELAY};

   logic signed [COORD_BITS-1:0] pointer_x = '0;
   logic signed [COORD_BITS-1:0] pointer_y = '0;
   logic [ACC_BITS-1:0]          travel_x = '0;     // motion since last press
   logic [ACC_BITS-1:0]          travel_y = '0;
   logic [ACC_BITS-1:0]          stroke_x = '0;     // motion of the current touch
   logic [ACC_BITS-1:0]          stroke_y = '0;
   logic [ACC_BITS-1:0]          stroke_peak = '0;  // largest per-axis excursion
   logic [TIME_BITS-1:0]         contact_time = '0;
   logic                         hold_pending = 1'b0;
   logic [TIME_BITS-1:0]         click_time = '0;
   logic                         click_pending = 1'b0;
   logic [MASK_BITS-1:0]         buttons = '0;

   pointer_event_type burst[$];           // responses of the request being predicted
   pointer_event_type pending_events[$];  // responses still owed by the block
   pointer_event_type typed_burst[$];
   bit                typed_armed = 1'b0;

   int  fail_count = 0;
   int  counted = 0;            // requests issued, mouse-mode ticks excepted
   bit  idling = 1'b1;
   int  hold_off_requests = 0;
   logic [TIME_BITS-1:0] clock_ms = 32'd0;

   function automatic logic [ACC_BITS-1:0] magnitude(logic [ACC_BITS-1:0] g);
      return g[ACC_BITS-1] ? -g : g;
   endfunction

   // Snapshot of position, buttons and totals at the moment of emission.
   function automatic void post_event(event_type ev, button_type btn,
                                      logic signed [STEP_BITS-1:0] sx,
                                      logic signed [STEP_BITS-1:0] sy);
      pointer_event_type e;
      e.event_res   = ev;
      e.button_id   = btn;
      e.move_dx     = sx;
      e.move_dy     = sy;
      e.pos_x       = pointer_x;
      e.pos_y       = pointer_y;
      e.button_mask = buttons;
      e.total_dx    = travel_x;
      e.total_dy    = travel_y;
      e.last        = 1'b0;
      burst.push_back(e);
   endfunction

   function automatic void recognize(kind_type kind, logic signed [COORD_BITS-1:0] px,
                                     logic signed [COORD_BITS-1:0] py,
                                     logic [TIME_BITS-1:0] now);
      logic signed [STEP_BITS-1:0] sx, sy;
      logic [ACC_BITS-1:0]         m;
      logic [TIME_BITS-1:0]        since_press, since_click;
      burst.delete();
      case (kind)
         KIND_PRESS: begin
            travel_x = '0;
            travel_y = '0;
            if (!settings.touch_mode) begin
               buttons |= MASK_PRIMARY;
               pointer_x = px;
               pointer_y = py;
               post_event(EV_DOWN, BTN_PRIMARY, '0, '0);
            end else begin
               contact_time = now;
               hold_pending = 1'b1;
               stroke_x = '0;
               stroke_y = '0;
               stroke_peak = '0;
               // a click still down from the last tap goes up first, at the old position
               if (click_pending) begin
                  buttons &= ~MASK_PRIMARY;
                  post_event(EV_UP, BTN_PRIMARY, '0, '0);
                  click_pending = 1'b0;
               end
               pointer_x = px;
               pointer_y = py;
               // move goes out before the contact bit is set
               post_event(EV_MOVE, BTN_PRIMARY, '0, '0);
               buttons |= MASK_CONTACT;
               post_event(EV_DOWN, BTN_CONTACT, '0, '0);
            end
         end
         KIND_MOVE, KIND_RELEASE: begin
            sx = {px[COORD_BITS-1], px} - {pointer_x[COORD_BITS-1], pointer_x};
            sy = {py[COORD_BITS-1], py} - {pointer_y[COORD_BITS-1], pointer_y};
            travel_x += {{(ACC_BITS-STEP_BITS){sx[STEP_BITS-1]}}, sx};
            travel_y += {{(ACC_BITS-STEP_BITS){sy[STEP_BITS-1]}}, sy};
            stroke_x += {{(ACC_BITS-STEP_BITS){sx[STEP_BITS-1]}}, sx};
            stroke_y += {{(ACC_BITS-STEP_BITS){sy[STEP_BITS-1]}}, sy};
            m = magnitude(stroke_x);
            if (magnitude(stroke_y) > m) m = magnitude(stroke_y);
            if (m > stroke_peak) stroke_peak = m;
            pointer_x = px;
            pointer_y = py;
            if (kind == KIND_MOVE) begin
               post_event(EV_MOVE, BTN_PRIMARY, sx, sy);
            end else if (!settings.touch_mode) begin
               // mouse release always reports primary up
               buttons &= ~MASK_PRIMARY;
               post_event(EV_UP, BTN_PRIMARY, '0, '0);
            end else if ((buttons & MASK_CONTACT) != '0) begin
               buttons &= ~MASK_CONTACT;
               post_event(EV_UP, BTN_CONTACT, '0, '0);
               if (stroke_peak < {16'd0, settings.still_radius}) begin
                  buttons |= MASK_PRIMARY;
                  post_event(EV_DOWN, BTN_PRIMARY, '0, '0);
                  hold_pending = 1'b0;
                  click_time = now;
                  click_pending = 1'b1;
               end
            end else if ((buttons & MASK_HOLD) != '0) begin
               buttons &= ~MASK_HOLD;
               post_event(EV_UP, BTN_HOLD, '0, '0);
            end
         end
         default: begin
            if (settings.touch_mode) begin
               since_press = now - contact_time;
               since_click = now - click_time;
               if (hold_pending && since_press > {16'd0, settings.hold_threshold_ms} &&
                   stroke_peak < {16'd0, settings.still_radius}) begin
                  buttons &= ~MASK_CONTACT;
                  post_event(EV_UP, BTN_CONTACT, '0, '0);
                  buttons |= MASK_HOLD;
                  post_event(EV_DOWN, BTN_HOLD, '0, '0);
                  hold_pending = 1'b0;
               end else if (hold_pending &&
                            since_press > {16'd0, settings.hold_threshold_ms}) begin
                  hold_pending = 1'b0;
               end else if (click_pending &&
                            since_click > {16'd0, settings.release_delay_ms}) begin
                  buttons &= ~MASK_PRIMARY;
                  post_event(EV_UP, BTN_PRIMARY, '0, '0);
                  click_pending = 1'b0;
               end
            end
         end
      endcase
      if (burst.size() > 0) burst[burst.size()-1].last = 1'b1;
   endfunction

   // ---------------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------------
   // Idle run length: mostly short, now and then long.
   function automatic int run_length();
      return ($urandom_range(0, 19) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
   endfunction

   function automatic cfg_type settings_of(bit tm, int thr, int rad, int del);
      cfg_type c;
      c.touch_mode        = tm;
      c.hold_threshold_ms = 16'(thr);
      c.still_radius      = 16'(rad);
      c.release_delay_ms  = 16'(del);
      return c;
   endfunction

   function automatic script_row_type blank_row();
      script_row_type r;
      r.op          = ROW_REQUEST;
      r.kind        = KIND_PRESS;
      r.x           = '0;
      r.y           = '0;
      r.t           = '0;
      r.cfg         = '0;
      r.typed       = 1'b0;
      r.typed_count = 0;
      r.ev          = EV_MOVE;
      r.btn         = BTN_PRIMARY;
      r.mask        = '0;
      return r;
   endfunction

   function automatic script_row_type req_row(kind_type k, int x, int y, logic [31:0] t);
      script_row_type r;
      r = blank_row();
      r.op   = ROW_REQUEST;
      r.kind = k;
      r.x    = 16'(x);
      r.y    = 16'(y);
      r.t    = t;
      return r;
   endfunction

   function automatic script_row_type settings_row(cfg_type c);
      script_row_type r;
      r = blank_row();
      r.op  = ROW_SETTINGS;
      r.cfg = c;
      return r;
   endfunction

   function automatic script_row_type typed_row(script_row_type r, int cnt, event_type ev,
                                                button_type btn,
                                                logic [MASK_BITS-1:0] mask);
      r.typed       = 1'b1;
      r.typed_count = cnt;
      r.ev          = ev;
      r.btn         = btn;
      r.mask        = mask;
      return r;
   endfunction

   // Time stamps step mostly a little, sometimes right around the threshold or
   // the click delay, and now and then jump anywhere (wraps included).
   function automatic logic [TIME_BITS-1:0] advance();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: clock_ms += $urandom_range(0, 30);
         5, 6, 7: clock_ms += settings.hold_threshold_ms + $urandom_range(0, 2) - 1;
         8: clock_ms += settings.release_delay_ms + $urandom_range(0, 2) - 1;
         default: clock_ms += $urandom;
      endcase
      return clock_ms;
   endfunction

   // Offer one request, hold it until accepted, then predict its responses.
   task automatic issue(kind_type kind, logic [COORD_BITS-1:0] x, logic [COORD_BITS-1:0] y,
                        logic [TIME_BITS-1:0] t);
      int gap;
      gap = (idling && $urandom_range(0, 2) == 0) ? run_length() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_kind     <= kind;
      req_pos_x_in <= x;
      req_pos_y_in <= y;
      req_time_ms  <= t;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      recognize(kind, x, y, t);
      if (typed_armed) begin
         burst = typed_burst;
         typed_armed = 1'b0;
      end
      foreach (burst[i]) pending_events.push_back(burst[i]);
      if (!(kind == KIND_TICK && !settings.touch_mode)) counted++;
   endtask

   // Stop offering, wait for every owed response, then let silent requests drain.
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_events.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Write all four registers back to back; only called while the block is idle.
   task automatic apply_settings(cfg_type c);
      logic [CFG_BITS-2:0] junk;
      junk = (CFG_BITS-1)'($urandom);   // upper bits of the mode write must be ignored
      csr_wr_en <= 1'b1;
      csr_index <= CSR_TOUCH_MODE;
      csr_wdata <= {junk, c.touch_mode};
      @(posedge clock);
      csr_index <= CSR_HOLD_THRESHOLD;
      csr_wdata <= c.hold_threshold_ms;
      @(posedge clock);
      csr_index <= CSR_STILL_RADIUS;
      csr_wdata <= c.still_radius;
      @(posedge clock);
      csr_index <= CSR_RELEASE_DELAY;
      csr_wdata <= c.release_delay_ms;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      settings = c;
   endtask

   // Random touch: press, a few moves and ticks, usually a release, trailing ticks.
   task automatic random_gesture();
      logic signed [COORD_BITS-1:0] gx, gy;
      int spread;
      if ($urandom_range(0, 7) == 0) clock_ms = $urandom;
      gx = 16'($urandom);
      gy = 16'($urandom);
      spread = ($urandom_range(0, 3) == 0) ? 40 : 4;
      issue(KIND_PRESS, gx, gy, advance());
      repeat ($urandom_range(0, 4)) begin
         if ($urandom_range(0, 3) == 0) begin
            issue(KIND_TICK, 16'($urandom), 16'($urandom), advance());
         end else begin
            gx = gx + 16'($urandom_range(0, 2 * spread) - spread);
            gy = gy + 16'($urandom_range(0, 2 * spread) - spread);
            issue(KIND_MOVE, gx, gy, advance());
         end
      end
      if ($urandom_range(0, 4) != 0) begin
         if ($urandom_range(0, 1) == 0) gx = gx + 16'($urandom_range(0, 2 * spread) - spread);
         issue(KIND_RELEASE, gx, gy, advance());
      end
      repeat ($urandom_range(0, 2)) issue(KIND_TICK, 16'($urandom), 16'($urandom), advance());
   endtask

   task automatic random_phase(cfg_type c, int n, bit calm, bit squeeze, bit pause);
      int         goal;
      bit         squeezed, paused;
      logic [1:0] k;
      settle();
      apply_settings(c);
      idling   = !calm;
      goal     = counted + n;
      squeezed = 1'b0;
      paused   = 1'b0;
      while (counted < goal) begin
         if (squeeze && !squeezed && counted >= goal - n / 2) begin
            hold_off_requests++;   // receiver holds off while we keep offering
            squeezed = 1'b1;
         end
         if (pause && !paused && counted >= goal - n / 2) begin
            settle();              // sender waits out every owed response
            paused = 1'b1;
         end
         if ($urandom_range(0, 4) == 0) begin
            // noise: any kind, any position, any time stamp
            k = 2'($urandom);
            issue(kind_type'(k), 16'($urandom), 16'($urandom), $urandom);
         end else begin
            random_gesture();
         end
      end
   endtask

   // ---------------------------------------------------------------------------
   // Response side: random stall runs plus the long hold-off on request.
   // ---------------------------------------------------------------------------
   initial begin : rsp_backpressure
      int stall_left;
      int hold_offs_served;
      stall_left = 0;
      hold_offs_served = 0;
      forever begin
         @(posedge clock);
         if (hold_off_requests != hold_offs_served) begin
            hold_offs_served++;
            stall_left = HOLD_OFF_CYCLES;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (idling && $urandom_range(0, 4) == 0) begin
            stall_left = run_length() - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0h, got %0h", name, want, got);
         fail_count++;
      end
   endfunction

   // Every accepted response is matched against the oldest owed one.
   always @(posedge clock) begin
      pointer_event_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_events.size() == 0) begin
            $error("response with no request owing one: event %0d button %0d",
                   rsp_event_res, rsp_button_id);
            fail_count++;
         end else begin
            want = pending_events.pop_front();
            check_field("event_res", 32'(want.event_res), 32'(rsp_event_res));
            check_field("button_id", 32'(want.button_id), 32'(rsp_button_id));
            check_field("move_dx", 32'(want.move_dx), 32'(rsp_move_dx));
            check_field("move_dy", 32'(want.move_dy), 32'(rsp_move_dy));
            check_field("pos_x", 32'(want.pos_x), 32'(rsp_pos_x));
            check_field("pos_y", 32'(want.pos_y), 32'(rsp_pos_y));
            check_field("button_mask", 32'(want.button_mask), 32'(rsp_button_mask));
            check_field("total_dx", want.total_dx, rsp_total_dx);
            check_field("total_dy", want.total_dy, rsp_total_dy);
            check_field("last", 32'(want.last), 32'(rsp_last));
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------------
   initial begin : stimulus
      script_row_type    script[$];
      pointer_event_type typed_ev;

      // Reset-default registers: touch mode, 500 ms hold, radius 10, 100 ms click.
      script.push_back(req_row(KIND_PRESS, 0, 0, 1000));
      script.push_back(req_row(KIND_MOVE, 3, 4, 1010));
      script.push_back(req_row(KIND_RELEASE, 3, 4, 1020));      // still: tap click
      script.push_back(req_row(KIND_TICK, 0, 0, 1100));         // click delay not over
      script.push_back(req_row(KIND_TICK, 0, 0, 1121));         // click goes up
      script.push_back(req_row(KIND_PRESS, 32767, -32768, 2000));
      script.push_back(req_row(KIND_TICK, 0, 0, 2500));         // exactly at threshold
      script.push_back(req_row(KIND_TICK, 0, 0, 2501));         // one past: hold
      script.push_back(req_row(KIND_MOVE, -32768, 32767, 2600)); // largest steps
      script.push_back(req_row(KIND_RELEASE, -32768, 32767, 2700)); // hold up
      script.push_back(req_row(KIND_RELEASE, -32768, 32767, 2710)); // nothing held
      script.push_back(req_row(KIND_PRESS, 0, 0, 3000));
      script.push_back(req_row(KIND_MOVE, 20, 0, 3010));
      script.push_back(req_row(KIND_RELEASE, 20, 0, 3020));     // moved: no tap
      // widen the radius so the still-armed press turns into a hold
      script.push_back(settings_row(settings_of(1, 500, 65535, 100)));
      script.push_back(req_row(KIND_TICK, 0, 0, 3600));
      // hold across the 32-bit time wrap
      script.push_back(req_row(KIND_PRESS, 100, -100, 32'hFFFF_FF00));
      script.push_back(req_row(KIND_TICK, 0, 0, 32'h0000_0100));
      // mouse mode
      script.push_back(settings_row(settings_of(0, 0, 0, 0)));
      script.push_back(typed_row(req_row(KIND_PRESS, 5, 5, 4000), 1, EV_DOWN, BTN_PRIMARY,
                                 MASK_HOLD | MASK_PRIMARY));
      script.push_back(typed_row(req_row(KIND_TICK, 7, 7, 4010), 0, EV_MOVE, BTN_PRIMARY,
                                 '0));
      script.push_back(req_row(KIND_RELEASE, 5, 5, 4020));
      script.push_back(req_row(KIND_RELEASE, 5, 5, 4030));      // primary up though not held
      // touch mode with every limit at zero
      script.push_back(settings_row(settings_of(1, 0, 0, 0)));
      script.push_back(req_row(KIND_PRESS, -1, 1, 5000));
      script.push_back(req_row(KIND_RELEASE, -1, 1, 5000));     // radius 0: never a tap

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (script[i]) begin
         if (script[i].op == ROW_SETTINGS) begin
            settle();
            apply_settings(script[i].cfg);
         end else begin
            if (script[i].typed) begin
               typed_burst.delete();
               if (script[i].typed_count != 0) begin
                  typed_ev = '{event_res: script[i].ev, button_id: script[i].btn,
                               move_dx: '0, move_dy: '0, pos_x: script[i].x,
                               pos_y: script[i].y, button_mask: script[i].mask,
                               total_dx: '0, total_dy: '0, last: 1'b1};
                  typed_burst.push_back(typed_ev);
               end
               typed_armed = 1'b1;
            end
            issue(script[i].kind, script[i].x, script[i].y, script[i].t);
         end
      end

      // Random phases: mixed, all-zero limits, all-max limits with no idling and
      // the long hold-off, mouse mode, full-range limits with a sender pause, tight.
      random_phase(settings_of(1, $urandom_range(20, 600), $urandom_range(1, 30),
                               $urandom_range(10, 300)), 50, 0, 0, 0);
      random_phase(settings_of(1, 0, 0, 0), 50, 0, 0, 0);
      random_phase(settings_of(1, 65535, 65535, 65535), 50, 1, 1, 0);
      random_phase(settings_of(0, $urandom_range(0, 65535), $urandom_range(0, 65535),
                               $urandom_range(0, 65535)), 40, 0, 0, 0);
      random_phase(settings_of(1, $urandom_range(0, 65535), $urandom_range(0, 65535),
                               $urandom_range(0, 65535)), 55, 0, 0, 1);
      random_phase(settings_of(1, $urandom_range(0, 100), $urandom_range(0, 8),
                               $urandom_range(0, 100)), 60, 0, 0, 0);

      settle();
      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin : watchdog
      #2_000_000;
      $display("Regression FAIL");
      $finish;
   end

endmodule

[filelist.f]
+incdir+rtl
rtl/tthr_pkg.sv
rtl/tthr_front.sv
rtl/tthr_queue.sv
rtl/tthr_back.sv
rtl/touch_tap_hold_recognizer.sv
dv/testbench.sv
